// ===== rtl/core/x86_muldiv_decimal_adjust_unit_core_macros.svh =====
// Assertion macros shared by the core.
`ifndef X86_MULDIV_DECIMAL_ADJUST_UNIT_CORE_MACROS_SVH
`define X86_MULDIV_DECIMAL_ADJUST_UNIT_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define XMD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked at the next clock edge.
`define XMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/xmd_pkg.sv =====
package xmd_pkg;

	localparam int unsigned NumCells = 16;

	typedef enum logic [2:0] {
		OP_MUL  = 3'd0,
		OP_IMUL = 3'd1,
		OP_DIV  = 3'd2,
		OP_IDIV = 3'd3,
		OP_DAA  = 3'd4,
		OP_DAS  = 3'd5,
		OP_AAA  = 3'd6,
		OP_AAS  = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic        word_size;
		logic [15:0] source_operand;
		logic [15:0] acc_in;
		logic [15:0] data_in;
		logic        carry_in;
		logic        aux_carry_in;
	} req_t;

	typedef struct packed {
		logic [15:0] acc_out;
		logic [15:0] data_out;
		logic        carry_out;
		logic        overflow_out;
		logic        aux_carry_out;
		logic        divide_error;
	} rsp_t;

	// Work carried from cell to cell along the divider chain.
	typedef struct packed {
		req_t        req;
		logic        is_div;
		logic        neg_q;
		logic        neg_r;
		logic        div_zero;
		logic        ovf;
		logic [16:0] rem;
		logic [31:0] num;
		logic [16:0] dvs;
		logic [15:0] quo;
		logic [31:0] prod;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t w;
	} lane_t;

endpackage

// ===== rtl/core/xmd_cell.sv =====
// One restoring-division step; a cell also advances the product and request.
module xmd_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           stall,
	input  xmd_pkg::lane_t lane_in,
	output xmd_pkg::lane_t lane_out
);
	import xmd_pkg::*;

	logic [17:0] trial;
	logic [16:0] shifted;
	work_t       nxt;
	logic        valid_q;
	work_t       w_q;

	always_comb begin
		nxt = lane_in.w;
		shifted = {lane_in.w.rem[15:0], lane_in.w.num[31]};
		trial = {1'b0, shifted} - {1'b0, lane_in.w.dvs};
		nxt.num = {lane_in.w.num[30:0], 1'b0};
		if (!trial[17]) begin
			nxt.rem = trial[16:0];
			nxt.quo = {lane_in.w.quo[14:0], 1'b1};
		end else begin
			nxt.rem = shifted;
			nxt.quo = {lane_in.w.quo[14:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!stall) begin
			valid_q <= lane_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			w_q <= nxt;
		end
	end

	assign lane_out = {valid_q, w_q};
endmodule

// ===== rtl/core/xmd_front.sv =====
// Entry stage: operand magnitudes for division and the full product.
module xmd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           stall,
	input  logic           in_valid,
	input  xmd_pkg::req_t  req,
	output xmd_pkg::lane_t lane_out
);
	import xmd_pkg::*;

	work_t       w;
	logic        sgn;
	logic        neg_d;
	logic [16:0] ma, mb;
	logic [33:0] p;
	logic [31:0] mag;
	logic        valid_q;
	work_t       w_q;

	always_comb begin
		w = '0;
		w.req = req;
		sgn = (req.req_type == OP_IMUL) || (req.req_type == OP_IDIV);
		if (req.word_size) begin
			ma = {sgn & req.acc_in[15], req.acc_in};
			mb = {sgn & req.source_operand[15], req.source_operand};
		end else begin
			ma = {{9{sgn & req.acc_in[7]}}, req.acc_in[7:0]};
			mb = {{9{sgn & req.source_operand[7]}}, req.source_operand[7:0]};
		end
		p = 34'($signed(ma) * $signed(mb));
		w.prod = p[31:0];
		w.is_div = (req.req_type == OP_DIV) || (req.req_type == OP_IDIV);
		if (req.word_size) begin
			mag = {req.data_in, req.acc_in};
			w.dvs = {1'b0, req.source_operand};
		end else begin
			mag = {req.acc_in, 16'h0000};
			w.dvs = {9'd0, req.source_operand[7:0]};
		end
		neg_d = req.word_size ? req.source_operand[15] : req.source_operand[7];
		w.neg_r = 1'b0;
		w.neg_q = 1'b0;
		if (req.req_type == OP_IDIV) begin
			w.neg_r = mag[31];
			w.neg_q = mag[31] ^ neg_d;
			if (mag[31]) begin
				mag = 32'd0 - mag;
			end
			if (neg_d) begin
				w.dvs = req.word_size ? 17'h10000 - {1'b0, req.source_operand}
					: 17'h100 - {9'd0, req.source_operand[7:0]};
			end
		end
		// A word dividend preloads its high half as the partial remainder, so the
		// sixteen cells only shift in the low half.
		if (req.word_size) begin
			w.rem = {1'b0, mag[31:16]};
			w.num = {mag[15:0], 16'h0000};
		end else begin
			w.rem = 17'd0;
			w.num = mag;
		end
		w.div_zero = (w.dvs == 17'd0);
		w.ovf = req.word_size && (w.rem >= w.dvs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			w_q <= w;
		end
	end

	assign lane_out = {valid_q, w_q};
endmodule

// ===== rtl/core/x86_muldiv_decimal_adjust_unit_core.sv =====
// Multiply, divide and decimal-adjust unit for the 16-bit x86 integer ops.
// A transaction passes through one entry stage that forms the product and
// operand magnitudes, sixteen division cells in a chain (one quotient bit each,
// a restoring subtract of up to 17 bits), and one result stage that fixes
// signs, checks quotient range and performs the decimal adjusts. The chain
// advances whenever the output stage is free or being drained, so one
// transaction is taken every cycle in steady state.
// Divide error leaves AX, DX, CF and AF unchanged; OF is set only by multiplies.
module x86_muldiv_decimal_adjust_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  xmd_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output xmd_pkg::rsp_t out_data
);
	import xmd_pkg::*;
`include "x86_muldiv_decimal_adjust_unit_core_macros.svh"

	lane_t chain [NumCells+1];
	logic  stall;
	rsp_t  rsp;

	// The pipeline only stops when a result is held and not being taken.
	assign stall = out_valid && !out_ready;
	assign in_ready = !stall;

	xmd_front u_front (
		.clk(clk), .arst_n(arst_n), .stall(stall),
		.in_valid(in_valid && in_ready), .req(in_data), .lane_out(chain[0])
	);

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		xmd_cell u_cell (
			.clk(clk), .arst_n(arst_n), .stall(stall),
			.lane_in(chain[i]), .lane_out(chain[i+1])
		);
	end

	work_t       w;
	logic [15:0] q, r;
	logic        de;
	logic [7:0]  al, old;
	logic        cf, af, hi;
	logic [15:0] ax2;

	always_comb begin
		w = chain[NumCells].w;
		rsp.acc_out = w.req.acc_in;
		rsp.data_out = w.req.data_in;
		rsp.carry_out = w.req.carry_in;
		rsp.aux_carry_out = w.req.aux_carry_in;
		rsp.overflow_out = 1'b0;
		rsp.divide_error = 1'b0;
		q = w.neg_q ? 16'd0 - w.quo : w.quo;
		r = w.neg_r ? 16'd0 - w.rem[15:0] : w.rem[15:0];
		de = 1'b0;
		hi = 1'b0;
		al = w.req.acc_in[7:0];
		old = al;
		cf = w.req.carry_in;
		af = w.req.aux_carry_in;
		ax2 = 16'd0;
		case (op_t'(w.req.req_type))
			OP_MUL, OP_IMUL: begin
				if (w.req.req_type == OP_MUL) begin
					hi = w.req.word_size ? (w.prod[31:16] != 16'd0) : (w.prod[15:8] != 8'd0);
				end else begin
					hi = w.req.word_size ? (w.prod[31:16] != {16{w.prod[15]}})
						: (w.prod[15:8] != {8{w.prod[7]}});
				end
				rsp.acc_out = w.prod[15:0];
				if (w.req.word_size) begin
					rsp.data_out = w.prod[31:16];
				end
				rsp.carry_out = hi;
				rsp.overflow_out = hi;
			end
			OP_DIV, OP_IDIV: begin
				// A word quotient magnitude fits in 16 bits only if the high half
				// of the dividend magnitude was below the divisor.
				if (w.div_zero) begin
					de = 1'b1;
				end else if (w.req.word_size) begin
					if (w.req.req_type == OP_DIV) begin
						de = w.ovf;
					end else begin
						de = w.ovf || (w.quo > (w.neg_q ? 16'h8000 : 16'h7FFF));
					end
				end else begin
					if (w.req.req_type == OP_DIV) begin
						de = (w.quo > 16'h00FF);
					end else begin
						de = (w.quo > (w.neg_q ? 16'h0080 : 16'h007F));
					end
				end
				if (!de) begin
					if (w.req.word_size) begin
						rsp.acc_out = q;
						rsp.data_out = r;
					end else begin
						rsp.acc_out = {r[7:0], q[7:0]};
					end
				end
			end
			OP_DAA, OP_DAS: begin
				if (al[3:0] > 4'd9 || af) begin
					af = 1'b1;
					al = (w.req.req_type == OP_DAS) ? old - 8'd6 : old + 8'd6;
					cf = cf || ((w.req.req_type == OP_DAS) ? (al >= old) : (al < old));
				end else begin
					af = 1'b0;
				end
				if (al > 8'h99 || cf) begin
					cf = 1'b1;
					al = (w.req.req_type == OP_DAS) ? al - 8'h60 : al + 8'h60;
				end else begin
					cf = 1'b0;
				end
				rsp.acc_out = {w.req.acc_in[15:8], al};
				rsp.carry_out = cf;
				rsp.aux_carry_out = af;
			end
			default: begin
				hi = (w.req.acc_in[3:0] > 4'd9) || w.req.aux_carry_in;
				ax2 = w.req.acc_in;
				if (hi) begin
					ax2 = (w.req.req_type == OP_AAA) ? w.req.acc_in + 16'd262
						: w.req.acc_in - 16'd262;
				end
				rsp.acc_out = {ax2[15:8], 4'h0, ax2[3:0]};
				rsp.carry_out = hi;
				rsp.aux_carry_out = hi;
			end
		endcase
		rsp.divide_error = de;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!stall) begin
			out_valid <= chain[NumCells].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			out_data <= rsp;
		end
	end

	`XMD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result lost")
	`XMD_ASSERT_IMPL(a_ready, out_valid && !out_ready, !in_ready, "accepted while stalled")
	`XMD_ASSERT_IMPL(a_de, out_valid && out_data.divide_error, !out_data.overflow_out, "OF with divide error")
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Multiply, divide and decimal-adjust unit testbench.
module testbench;
	import xmd_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;

	x86_muldiv_decimal_adjust_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// The settle time at the end is longer than the core's pipeline latency.
	localparam int unsigned SettleCycles = 40;
	localparam int unsigned CycleLimit = 400000;
	localparam int ReqBits = $bits(req_t);

	// Instructions waiting to be driven, and register results waiting to be seen.
	req_t pending_instrs[$];
	rsp_t expected_regs[$];

	// Idle percentages for each side. The stimulus process changes them between phases.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic hold_sender;

	int unsigned mismatches;
	int unsigned unexpected;
	int unsigned sent_count;
	int unsigned recv_count;
	int unsigned div_errors;
	int unsigned cycles;

	// One period is 20 ns.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// This models the unit's arithmetic. It runs on the instruction fields and
	// returns the registers and flags that the core should write back.
	function automatic rsp_t predict_regs(req_t r);
		rsp_t res;
		logic [31:0] prod;
		logic [31:0] num;
		logic [31:0] quo;
		longint sn;
		longint sd;
		longint sq;
		longint sr;
		longint qlo;
		longint qhi;
		logic [7:0] al;
		logic [7:0] old_al;
		logic hi_sig;
		logic adj;
		logic de;
		logic [15:0] ax_tmp;
		res.acc_out = r.acc_in;
		res.data_out = r.data_in;
		res.carry_out = r.carry_in;
		res.overflow_out = 1'b0;
		res.aux_carry_out = r.aux_carry_in;
		res.divide_error = 1'b0;
		de = 1'b0;
		case (op_t'(r.req_type))
			OP_MUL, OP_IMUL: begin
				if (op_t'(r.req_type) == OP_MUL) begin
					if (r.word_size) begin
						prod = {16'd0, r.source_operand} * {16'd0, r.acc_in};
						hi_sig = prod[31:16] != 16'd0;
					end else begin
						prod = {24'd0, r.source_operand[7:0]} * {24'd0, r.acc_in[7:0]};
						hi_sig = prod[15:8] != 8'd0;
					end
				end else begin
					if (r.word_size) begin
						prod = 32'($signed(r.source_operand) * $signed(r.acc_in));
						hi_sig = prod != {{16{prod[15]}}, prod[15:0]};
					end else begin
						prod = {16'd0, 16'($signed(r.source_operand[7:0]) *
							$signed(r.acc_in[7:0]))};
						hi_sig = prod[15:0] != {{8{prod[7]}}, prod[7:0]};
					end
				end
				res.acc_out = prod[15:0];
				if (r.word_size)
					res.data_out = prod[31:16];
				res.carry_out = hi_sig;
				res.overflow_out = hi_sig;
			end
			OP_DIV: begin
				if (r.word_size) begin
					num = {r.data_in, r.acc_in};
					if (r.source_operand == 16'd0) begin
						de = 1'b1;
					end else begin
						quo = num / {16'd0, r.source_operand};
						if (quo > 32'hFFFF) begin
							de = 1'b1;
						end else begin
							res.acc_out = quo[15:0];
							res.data_out = 16'(num - quo * {16'd0, r.source_operand});
						end
					end
				end else begin
					if (r.source_operand[7:0] == 8'd0) begin
						de = 1'b1;
					end else begin
						quo = {16'd0, r.acc_in} / {24'd0, r.source_operand[7:0]};
						if (quo > 32'hFF) begin
							de = 1'b1;
						end else begin
							res.acc_out = {8'(r.acc_in - quo[15:0] *
								{8'd0, r.source_operand[7:0]}), quo[7:0]};
						end
					end
				end
			end
			OP_IDIV: begin
				if (r.word_size) begin
					sn = longint'($signed({r.data_in, r.acc_in}));
					sd = longint'($signed(r.source_operand));
					qlo = -32768;
					qhi = 32767;
				end else begin
					sn = longint'($signed(r.acc_in));
					sd = longint'($signed(r.source_operand[7:0]));
					qlo = -128;
					qhi = 127;
				end
				if (sd == 0) begin
					de = 1'b1;
				end else begin
					// SystemVerilog division truncates toward zero, as the x86 does.
					sq = sn / sd;
					sr = sn % sd;
					if (sq < qlo || sq > qhi) begin
						de = 1'b1;
					end else if (r.word_size) begin
						res.acc_out = sq[15:0];
						res.data_out = sr[15:0];
					end else begin
						res.acc_out = {sr[7:0], sq[7:0]};
					end
				end
			end
			OP_DAA, OP_DAS: begin
				al = r.acc_in[7:0];
				old_al = al;
				if (al[3:0] > 4'd9 || r.aux_carry_in) begin
					res.aux_carry_out = 1'b1;
					if (op_t'(r.req_type) == OP_DAS) begin
						al = al - 8'h06;
						res.carry_out = r.carry_in || (al >= old_al);
					end else begin
						al = al + 8'h06;
						res.carry_out = r.carry_in || (al < old_al);
					end
				end else begin
					res.aux_carry_out = 1'b0;
				end
				// The second test looks at AL after the low-nibble fix, not at the original.
				if (al > 8'h99 || res.carry_out) begin
					res.carry_out = 1'b1;
					al = (op_t'(r.req_type) == OP_DAS) ? al - 8'h60 : al + 8'h60;
				end else begin
					res.carry_out = 1'b0;
				end
				res.acc_out = {r.acc_in[15:8], al};
			end
			default: begin
				adj = (r.acc_in[3:0] > 4'd9) || r.aux_carry_in;
				res.aux_carry_out = adj;
				res.carry_out = adj;
				ax_tmp = r.acc_in;
				if (adj)
					ax_tmp = (op_t'(r.req_type) == OP_AAA) ? ax_tmp + 16'd262 :
						ax_tmp - 16'd262;
				res.acc_out = {ax_tmp[15:8], 4'd0, ax_tmp[3:0]};
			end
		endcase
		if (de) begin
			res.acc_out = r.acc_in;
			res.data_out = r.data_in;
			res.carry_out = r.carry_in;
			res.aux_carry_out = r.aux_carry_in;
			res.overflow_out = 1'b0;
			res.divide_error = 1'b1;
		end
		return res;
	endfunction

	// The driver keeps valid high and the payload steady until the transaction is
	// accepted. When an instruction is accepted, the next one is loaded in the same
	// assignment, so valid is never dropped and raised again within one step.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (!in_valid || in_ready) begin
				if (pending_instrs.size() != 0 && !hold_sender &&
					$urandom_range(99, 0) >= send_idle_pct) begin
					in_data <= pending_instrs[0];
					expected_regs.push_back(predict_regs(pending_instrs[0]));
					void'(pending_instrs.pop_front());
					in_valid <= 1'b1;
					sent_count <= sent_count + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The expectation is queued when the instruction is launched. The core cannot
	// answer before the instruction is accepted, so this order is still safe.

	// Monitor: the ready level is sampled at the edge, then a new one is drawn.
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				recv_count <= recv_count + 1;
				if (expected_regs.size() == 0) begin
					unexpected <= unexpected + 1;
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("Unexpected result transaction: %p", out_data);
				end else begin
					exp_r = expected_regs.pop_front();
					if (exp_r.divide_error)
						div_errors <= div_errors + 1;
					if (out_data !== exp_r) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display({"Mismatch: acc %h/%h dx %h/%h cf %b/%b ",
								"of %b/%b af %b/%b de %b/%b"},
								exp_r.acc_out, out_data.acc_out,
								exp_r.data_out, out_data.data_out,
								exp_r.carry_out, out_data.carry_out,
								exp_r.overflow_out, out_data.overflow_out,
								exp_r.aux_carry_out, out_data.aux_carry_out,
								exp_r.divide_error, out_data.divide_error);
					end
				end
			end
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// The watchdog stops a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	function automatic req_t make_instr(op_t op, logic w, logic [15:0] src, logic [15:0] ax,
		logic [15:0] dx, logic cf, logic af);
		req_t r;
		r.req_type = op;
		r.word_size = w;
		r.source_operand = src;
		r.acc_in = ax;
		r.data_in = dx;
		r.carry_in = cf;
		r.aux_carry_in = af;
		return r;
	endfunction

	task automatic queue_instr(op_t op, logic w, logic [15:0] src, logic [15:0] ax,
		logic [15:0] dx, logic cf, logic af);
		pending_instrs.push_back(make_instr(op, w, src, ax, dx, cf, af));
	endtask

	// Random instructions. Divides are usually set up so the quotient fits, which
	// keeps most of them away from the divide-error path.
	function automatic req_t random_instr();
		req_t r;
		r = req_t'(ReqBits'({$urandom, $urandom}));
		if (r.req_type inside {OP_DIV, OP_IDIV} && $urandom_range(3, 0) != 0) begin
			if (r.word_size) begin
				if (r.source_operand == 16'd0)
					r.source_operand = 16'd1;
				r.data_in = 16'($urandom) % r.source_operand;
				if (r.req_type == OP_IDIV)
					r.data_in = {16{r.acc_in[15]}};
			end else begin
				r.acc_in[15:8] = 8'($urandom_range(255, 0)) >> $urandom_range(8, 1);
			end
		end
		return r;
	endfunction

	// Waits until every issued instruction has its result.
	task automatic drain_all();
		while (pending_instrs.size() != 0 || in_valid || expected_regs.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int unsigned count, int unsigned sidle, int unsigned rstall);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		repeat (count)
			pending_instrs.push_back(random_instr());
		drain_all();
	endtask

	initial begin
		int op_i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_sender = 1'b0;
		mismatches = 0;
		unexpected = 0;
		sent_count = 0;
		recv_count = 0;
		div_errors = 0;
		cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cases: extreme operands, every opcode, and each special case.
		queue_instr(OP_MUL, 1'b1, 16'hFFFF, 16'hFFFF, 16'h1234, 1'b0, 1'b1);
		queue_instr(OP_MUL, 1'b0, 16'h00FF, 16'hAAFF, 16'h5555, 1'b1, 1'b0);
		queue_instr(OP_MUL, 1'b0, 16'hFF02, 16'h0003, 16'h0000, 1'b1, 1'b1);
		queue_instr(OP_IMUL, 1'b1, 16'h8000, 16'h8000, 16'h0000, 1'b0, 1'b0);
		queue_instr(OP_IMUL, 1'b1, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1);
		queue_instr(OP_IMUL, 1'b0, 16'h0080, 16'h0080, 16'h0000, 1'b0, 1'b1);
		queue_instr(OP_IMUL, 1'b0, 16'h00FF, 16'h0005, 16'h0000, 1'b1, 1'b0);
		// Zero divisor, an overflowing quotient, and exact boundaries.
		queue_instr(OP_DIV, 1'b1, 16'h0000, 16'h1234, 16'h0001, 1'b1, 1'b1);
		queue_instr(OP_DIV, 1'b1, 16'h0001, 16'hFFFF, 16'h0001, 1'b0, 1'b1);
		queue_instr(OP_DIV, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1, 1'b0);
		queue_instr(OP_DIV, 1'b0, 16'hFF00, 16'h0100, 16'h7777, 1'b0, 1'b0);
		queue_instr(OP_DIV, 1'b0, 16'h0001, 16'h00FF, 16'h7777, 1'b1, 1'b1);
		queue_instr(OP_DIV, 1'b0, 16'h0001, 16'h0100, 16'h7777, 1'b1, 1'b1);
		queue_instr(OP_IDIV, 1'b1, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b0, 1'b0);
		queue_instr(OP_IDIV, 1'b1, 16'hFFFF, 16'h8000, 16'h0000, 1'b1, 1'b1);
		queue_instr(OP_IDIV, 1'b1, 16'h0007, 16'hFFF9, 16'hFFFF, 1'b0, 1'b1);
		queue_instr(OP_IDIV, 1'b0, 16'h00FF, 16'hFF80, 16'h0000, 1'b0, 1'b0);
		queue_instr(OP_IDIV, 1'b0, 16'h00FF, 16'h0080, 16'h0000, 1'b1, 1'b0);
		queue_instr(OP_IDIV, 1'b0, 16'h0000, 16'h0080, 16'h0000, 1'b1, 1'b1);
		queue_instr(OP_DAA, 1'b0, 16'h0000, 16'h129A, 16'h0000, 1'b0, 1'b0);
		queue_instr(OP_DAA, 1'b1, 16'h0000, 16'hFF99, 16'h0000, 1'b1, 1'b1);
		queue_instr(OP_DAS, 1'b0, 16'h0000, 16'h3400, 16'h0000, 1'b0, 1'b1);
		queue_instr(OP_AAA, 1'b0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
		queue_instr(OP_AAS, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
		queue_instr(OP_AAS, 1'b1, 16'hFFFF, 16'h1205, 16'hFFFF, 1'b1, 1'b0);
		drain_all();

		// Random phases with different idle patterns. Before the last phase the
		// sender holds off for a while with the pipeline empty, then resumes.
		run_phase(300, 0, 0);
		run_phase(200, 80, 0);
		run_phase(200, 0, 80);
		run_phase(200, 21, 21);
		hold_sender = 1'b1;
		for (op_i = 0; op_i < 8; op_i++)
			pending_instrs.push_back(random_instr());
		repeat (SettleCycles) @(posedge clk);
		hold_sender = 1'b0;
		drain_all();
		run_phase(300, 0, 0);

		repeat (SettleCycles) @(posedge clk);
		$display("Covered %0d instructions of all eight opcodes with every idle pattern;",
			sent_count);
		$display("%0d results, %0d divide errors, %0d unexpected results", recv_count,
			div_errors, unexpected);
		if (mismatches == 0 && expected_regs.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== x86_muldiv_decimal_adjust_unit_core.f =====
+incdir+rtl/core
rtl/core/xmd_pkg.sv
rtl/core/xmd_cell.sv
rtl/core/xmd_front.sv
rtl/core/x86_muldiv_decimal_adjust_unit_core.sv
verif/testbench.sv
